### hdl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

	localparam int HEAP_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 6;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_ROUND  = 1'b0;
	localparam logic CFG_MSPLIT = 1'b1;

	localparam logic [12:0] MSPLIT_RESET = 13'd8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [11:0] offset;
		logic [1:0]  status;
	} res_t;

endpackage
`default_nettype wire

### hdl/ffa_mem.sv
`default_nettype none
module ffa_mem #(
	parameter int AW    = 13,
	parameter int DEPTH = 4097
) (
	input  wire logic          clk,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [AW-1:0] rd_len,
	output logic               rd_used,
	output logic      [AW-1:0] rd_prev,
	input  wire logic          wa_en,
	input  wire logic [AW-1:0] wa_addr,
	input  wire logic [AW-1:0] wa_len,
	input  wire logic          wa_used,
	input  wire logic          wp_en,
	input  wire logic [AW-1:0] wp_addr,
	input  wire logic [AW-1:0] wp_prev
);

	// length and in-use bit per header position
	logic [AW:0]   mem_a [DEPTH];
	// length of the preceding block
	logic [AW-1:0] mem_p [DEPTH];

	always_ff @(posedge clk) begin
		if (wa_en) begin
			mem_a[wa_addr] <= {wa_len, wa_used};
		end
		if (re) begin
			{rd_len, rd_used} <= mem_a[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wp_en) begin
			mem_p[wp_addr] <= wp_prev;
		end
		if (re) begin
			rd_prev <= mem_p[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl #(
	parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int AW           = $clog2(HEAP_BYTES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               idle,
	input  wire logic          opcode,
	input  wire logic [11:0]   request_bytes,
	input  wire logic [11:0]   release_offset,
	input  wire logic          round_to_four,
	input  wire logic [12:0]   min_split,
	output logic               done,
	output ffa_pkg::res_t      res,
	input  wire logic          take,
	output logic               re,
	output logic      [AW-1:0] raddr,
	input  wire logic [AW-1:0] rd_len,
	input  wire logic          rd_used,
	input  wire logic [AW-1:0] rd_prev,
	output logic               wa_en,
	output logic      [AW-1:0] wa_addr,
	output logic      [AW-1:0] wa_len,
	output logic               wa_used,
	output logic               wp_en,
	output logic      [AW-1:0] wp_addr,
	output logic      [AW-1:0] wp_prev
);

	localparam int CW = ((AW > 13) ? AW : 13) + 1;
	localparam logic [AW-1:0] H_A   = AW'(HEAP_BYTES);
	localparam logic [AW-1:0] HDR_A = AW'(HEADER_BYTES);

	localparam logic [4:0] S_INIT0  = 5'd0;
	localparam logic [4:0] S_INIT1  = 5'd1;
	localparam logic [4:0] S_IDLE   = 5'd2;
	localparam logic [4:0] S_AW_RD  = 5'd3;
	localparam logic [4:0] S_AW_CHK = 5'd4;
	localparam logic [4:0] S_ASPLIT = 5'd5;
	localparam logic [4:0] S_AMARK  = 5'd6;
	localparam logic [4:0] S_LW_RD  = 5'd7;
	localparam logic [4:0] S_LW_CHK = 5'd8;
	localparam logic [4:0] S_FW_RD  = 5'd9;
	localparam logic [4:0] S_FW_CHK = 5'd10;
	localparam logic [4:0] S_FN_RD  = 5'd11;
	localparam logic [4:0] S_FN_CHK = 5'd12;
	localparam logic [4:0] S_FP_RD  = 5'd13;
	localparam logic [4:0] S_FP_CHK = 5'd14;
	localparam logic [4:0] S_DONE   = 5'd15;

	logic [4:0]    state_q, state_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [CW-1:0] need_q, need_d;
	logic [AW-1:0] old_q, old_d;
	logic [AW-1:0] lf_q, lf_d;
	logic [AW-1:0] h_q, h_d;
	logic [AW-1:0] lenh_q, lenh_d;
	logic [AW-1:0] prevh_q, prevh_d;
	logic [AW-1:0] nx_q, nx_d;
	ffa_pkg::res_t res_q, res_d;

	logic [12:0]   size;
	logic [12:0]   msplit;
	logic [CW-1:0] off_w;
	logic [CW-1:0] rest_w;
	logic [AW:0]   lf_sum;
	logic [AW-1:0] len2;
	logic [AW-1:0] p_next;

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign res  = res_q;

	always_comb begin
		size = round_to_four ? (({1'b0, request_bytes} + 13'd3) & ~13'd3)
			: {1'b0, request_bytes};
		msplit = (min_split == 13'd0) ? 13'd1 : min_split;
		off_w  = CW'(release_offset);
		rest_w = CW'(rd_len) - need_q;
		lf_sum = {1'b0, lf_q} + {1'b0, rd_len};
		len2   = lenh_q + rd_len;
		p_next = pos_q + rd_len;

		state_d = state_q;
		pos_d   = pos_q;
		need_d  = need_q;
		old_d   = old_q;
		lf_d    = lf_q;
		h_d     = h_q;
		lenh_d  = lenh_q;
		prevh_d = prevh_q;
		nx_d    = nx_q;
		res_d   = res_q;
		re      = 1'b0;
		raddr   = pos_q;
		wa_en   = 1'b0;
		wa_addr = pos_q;
		wa_len  = old_q;
		wa_used = 1'b0;
		wp_en   = 1'b0;
		wp_addr = pos_q;
		wp_prev = old_q;

		case (state_q)
			S_INIT0: begin
				wa_en   = 1'b1;
				wa_addr = '0;
				wa_len  = H_A;
				wa_used = 1'b0;
				wp_en   = 1'b1;
				wp_addr = '0;
				wp_prev = '0;
				state_d = S_INIT1;
			end
			S_INIT1: begin
				// end marker
				wa_en   = 1'b1;
				wa_addr = H_A;
				wa_len  = '0;
				wa_used = 1'b1;
				wp_en   = 1'b1;
				wp_addr = H_A;
				wp_prev = H_A;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					res_d.offset = '0;
					res_d.status = ffa_pkg::ST_OK;
					if (opcode == ffa_pkg::OP_ALLOC) begin
						if (size == 13'd0) begin
							res_d.status = ffa_pkg::ST_ZERO;
							state_d      = S_DONE;
						end else begin
							need_d  = CW'(size) + CW'(HEADER_BYTES);
							pos_d   = lf_q;
							state_d = S_AW_RD;
						end
					end else begin
						if (off_w < CW'(HEADER_BYTES) || off_w >= CW'(HEAP_BYTES)) begin
							res_d.status = ffa_pkg::ST_RANGE;
							state_d      = S_DONE;
						end else begin
							h_d     = AW'(off_w - CW'(HEADER_BYTES));
							pos_d   = '0;
							state_d = S_FW_RD;
						end
					end
				end
			end
			S_AW_RD: begin
				if (pos_q >= H_A) begin
					res_d.status = ffa_pkg::ST_NOFIT;
					state_d      = S_DONE;
				end else begin
					re      = 1'b1;
					raddr   = pos_q;
					state_d = S_AW_CHK;
				end
			end
			S_AW_CHK: begin
				if (!rd_used && CW'(rd_len) >= need_q) begin
					old_d = rd_len;
					if (rest_w >= CW'(msplit)) begin
						wa_en   = 1'b1;
						wa_addr = pos_q + need_q[AW-1:0];
						wa_len  = rest_w[AW-1:0];
						wa_used = 1'b0;
						wp_en   = 1'b1;
						wp_addr = pos_q + need_q[AW-1:0];
						wp_prev = need_q[AW-1:0];
						state_d = S_ASPLIT;
					end else begin
						state_d = S_AMARK;
					end
				end else begin
					pos_d   = p_next;
					state_d = S_AW_RD;
				end
			end
			S_ASPLIT, S_AMARK: begin
				wa_en   = 1'b1;
				wa_addr = pos_q;
				wa_len  = (state_q == S_ASPLIT) ? need_q[AW-1:0] : old_q;
				wa_used = 1'b1;
				if (state_q == S_ASPLIT) begin
					wp_en   = 1'b1;
					wp_addr = pos_q + old_q;
					wp_prev = old_q - need_q[AW-1:0];
				end
				res_d.offset = 12'(CW'(pos_q) + CW'(HEADER_BYTES));
				state_d      = (lf_q == pos_q) ? S_LW_RD : S_DONE;
			end
			S_LW_RD: begin
				if (lf_q >= H_A) begin
					lf_d    = H_A;
					state_d = S_DONE;
				end else begin
					re      = 1'b1;
					raddr   = lf_q;
					state_d = S_LW_CHK;
				end
			end
			S_LW_CHK: begin
				if (rd_used) begin
					lf_d    = (lf_sum > {1'b0, H_A}) ? H_A : lf_sum[AW-1:0];
					state_d = S_LW_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FW_RD: begin
				re      = 1'b1;
				raddr   = pos_q;
				state_d = S_FW_CHK;
			end
			S_FW_CHK: begin
				if (pos_q == h_q) begin
					if (!rd_used) begin
						res_d.status = ffa_pkg::ST_RANGE;
						state_d      = S_DONE;
					end else begin
						lenh_d  = rd_len;
						prevh_d = rd_prev;
						if (lf_q > h_q) begin
							lf_d = h_q;
						end
						state_d = S_FN_RD;
					end
				end else if ({1'b0, pos_q} + {1'b0, rd_len} > {1'b0, h_q}) begin
					res_d.status = ffa_pkg::ST_RANGE;
					state_d      = S_DONE;
				end else begin
					pos_d   = p_next;
					state_d = S_FW_RD;
				end
			end
			S_FN_RD: begin
				re      = 1'b1;
				raddr   = h_q + lenh_q;
				state_d = S_FN_CHK;
			end
			S_FN_CHK: begin
				wa_en   = 1'b1;
				wa_addr = h_q;
				wa_used = 1'b0;
				if (!rd_used) begin
					wa_len  = len2;
					lenh_d  = len2;
					wp_en   = 1'b1;
					wp_addr = h_q + len2;
					wp_prev = len2;
					nx_d    = h_q + len2;
				end else begin
					wa_len = lenh_q;
					nx_d   = h_q + lenh_q;
				end
				state_d = (prevh_q != '0) ? S_FP_RD : S_DONE;
			end
			S_FP_RD: begin
				re      = 1'b1;
				raddr   = h_q - prevh_q;
				state_d = S_FP_CHK;
			end
			S_FP_CHK: begin
				if (!rd_used) begin
					wa_en   = 1'b1;
					wa_addr = h_q - prevh_q;
					wa_len  = len2;
					wa_used = 1'b0;
					wp_en   = 1'b1;
					wp_addr = nx_q;
					wp_prev = len2;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
			lf_q    <= '0;
		end else begin
			state_q <= state_d;
			lf_q    <= lf_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		need_q  <= need_d;
		old_q   <= old_d;
		h_q     <= h_d;
		lenh_q  <= lenh_d;
		prevh_q <= prevh_d;
		nx_q    <= nx_d;
		res_q   <= res_d;
	end

endmodule
`default_nettype wire

### hdl/first_fit_heap_allocator_unit.sv
// first-fit heap allocator with boundary-tag coalescing
// input channel (in_valid/in_ready) carries one request beat: opcode selects
// allocate (request_bytes) or free (release_offset). every request gives
// exactly one result beat on out_valid/out_ready: payload_offset and status.
// config channel (cfg_valid/cfg_ready) writes round_to_four (index 0) or
// min_split_bytes (index 1); it is always ready.
// block headers live in two synchronous memories (length/in-use and previous
// length); each header visited is read in one state and checked in the next.
// allocate: walk from the lowest free block to the first free block that fits,
// split off the rest if it reaches min_split, mark it used, and walk the lowest
// free pointer on past used blocks if it pointed at the block taken.
// free: walk from the heap start to the released block, then merge it with the
// free next and previous blocks. zero size and out-of-range offsets end without
// a walk. one request is in flight at a time; in_ready is high only when idle.
// after reset the block writes the initial free block and the end marker before in_ready rises.
// a stalled receiver holds the result in the output register; the next
// request may still be taken and worked on while the old beat waits.
`default_nettype none
module first_fit_heap_allocator_unit #(
	parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [11:0] request_bytes,
	input  wire logic [11:0] release_offset,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [11:0] payload_offset,
	output logic      [1:0]  status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);

	localparam int AW = $clog2(HEAP_BYTES + 1);

	logic          round_q;
	logic [12:0]   msplit_q;
	logic          out_valid_q;
	ffa_pkg::res_t out_q;
	logic          idle, done, take;
	ffa_pkg::res_t res;

	logic          re, wa_en, wa_used, wp_en, rd_used;
	logic [AW-1:0] raddr, rd_len, rd_prev, wa_addr, wa_len, wp_addr, wp_prev;

	assign cfg_ready      = 1'b1;
	assign in_ready       = idle;
	assign take           = done && (!out_valid_q || out_ready);
	assign out_valid      = out_valid_q;
	assign payload_offset = out_q.offset;
	assign status         = out_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q     <= 1'b0;
			msplit_q    <= ffa_pkg::MSPLIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == ffa_pkg::CFG_ROUND) begin
					round_q <= cfg_data[0];
				end else begin
					msplit_q <= cfg_data;
				end
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	ffa_ctrl #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.AW           (AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (in_valid),
		.idle           (idle),
		.opcode         (opcode),
		.request_bytes  (request_bytes),
		.release_offset (release_offset),
		.round_to_four  (round_q),
		.min_split      (msplit_q),
		.done           (done),
		.res            (res),
		.take           (take),
		.re             (re),
		.raddr          (raddr),
		.rd_len         (rd_len),
		.rd_used        (rd_used),
		.rd_prev        (rd_prev),
		.wa_en          (wa_en),
		.wa_addr        (wa_addr),
		.wa_len         (wa_len),
		.wa_used        (wa_used),
		.wp_en          (wp_en),
		.wp_addr        (wp_addr),
		.wp_prev        (wp_prev)
	);

	ffa_mem #(
		.AW    (AW),
		.DEPTH (HEAP_BYTES + 1)
	) u_mem (
		.clk     (clk),
		.re      (re),
		.raddr   (raddr),
		.rd_len  (rd_len),
		.rd_used (rd_used),
		.rd_prev (rd_prev),
		.wa_en   (wa_en),
		.wa_addr (wa_addr),
		.wa_len  (wa_len),
		.wa_used (wa_used),
		.wp_en   (wp_en),
		.wp_addr (wp_addr),
		.wp_prev (wp_prev)
	);

endmodule
`default_nettype wire

### hdl/ffa_chk.sv
`default_nettype none
module ffa_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [11:0] payload_offset,
	input wire logic [1:0]  status
);

	// a held result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_offset) && $stable(status))
		else $error("result beat changed while stalled");

	// only a granted allocation carries an offset
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffa_pkg::ST_OK |-> payload_offset == 12'd0)
		else $error("offset on failed request");

	// one request in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// nothing is taken while the headers are set up
	assert property (@(posedge clk) $rose(arst_n) |-> !in_ready)
		else $error("ready during header setup");

endmodule

bind first_fit_heap_allocator_unit ffa_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.payload_offset (payload_offset),
	.status         (status)
);
`default_nettype wire
